// ----- rtl/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console character engine package
// Screen geometry, field widths, character codes, register indexes and the
// structs that travel between the engine's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

  // Screen geometry.
  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int STATUS_ROWS = 1;
  localparam int TEXT_ROWS   = ROWS - STATUS_ROWS;
  localparam int CELLS       = COLUMNS * TEXT_ROWS;
  localparam int TAB_WIDTH   = 4;
  localparam int TAB_EDGE    = 4;

  // Field widths.
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int ADDR_W  = 11;
  localparam int DATA_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int PTR_W   = $clog2(CELLS + 1);
  localparam int CNT_W   = $clog2(TAB_WIDTH + 1);
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_W   = 3;

  // Character codes with a fixed meaning.
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;

  // Register indexes of the configuration port.
  localparam logic [REG_W-1:0] REG_TEXT_ATTR  = 3'd0;
  localparam logic [REG_W-1:0] REG_BLANK_ATTR = 3'd1;
  localparam logic [REG_W-1:0] REG_CODE_LEFT  = 3'd2;
  localparam logic [REG_W-1:0] REG_CODE_RIGHT = 3'd3;
  localparam logic [REG_W-1:0] REG_CODE_UP    = 3'd4;
  localparam logic [REG_W-1:0] REG_CODE_DOWN  = 3'd5;

  // Register reset values.
  localparam logic [CHAR_W-1:0] RST_TEXT_ATTR  = 8'd7;
  localparam logic [CHAR_W-1:0] RST_BLANK_ATTR = 8'd7;
  localparam logic [CHAR_W-1:0] RST_CODE_LEFT  = 8'd128;
  localparam logic [CHAR_W-1:0] RST_CODE_RIGHT = 8'd129;
  localparam logic [CHAR_W-1:0] RST_CODE_UP    = 8'd130;
  localparam logic [CHAR_W-1:0] RST_CODE_DOWN  = 8'd131;

  // Operation codes of an input transaction.
  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  // Configuration register contents.
  typedef struct packed {
    logic [CHAR_W-1:0] text_attr;
    logic [CHAR_W-1:0] blank_attr;
    logic [CHAR_W-1:0] code_left;
    logic [CHAR_W-1:0] code_right;
    logic [CHAR_W-1:0] code_up;
    logic [CHAR_W-1:0] code_down;
  } cfg_t;

  // Screen store write port.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ----- rtl/text_console_character_engine_top.sv -----
// ----------------------------------------------------------------------------
// Text console character engine
// Screen store of attribute and character cells with a cursor, driven by
// put-character, set-cursor, clear-screen and read-cell transactions.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o) takes one operation per
//   transaction; the output channel (out_valid_o/out_ready_i) returns exactly
//   one result per operation, in order. The APB-style port sets the
//   attributes and the arrow codes and should be written while idle.
//   After reset the store is cleared one cell per cycle, and in_ready_o
//   stays low until the pass is done. A scroll copies each text row up
//   by one row through the store's read and write ports, then blanks the
//   bottom row; backspace walks back one cell per cycle. One operation is
//   in work at a time, so a new transaction is accepted only once the
//   previous one has loaded its result. The result waits in an output
//   register; a stalled receiver does not block the next accept, only the
//   next result.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_character_engine_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tcce_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tcce_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tcce_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [tcce_pkg::CHAR_W-1:0]   char_code_i,
  input  wire logic [tcce_pkg::COL_W-1:0]    target_col_i,
  input  wire logic [tcce_pkg::ROW_W-1:0]    target_row_i,
  input  wire logic [tcce_pkg::ADDR_W-1:0]   cell_index_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [tcce_pkg::DATA_W-1:0]   cell_data_o,
  output logic      [tcce_pkg::ROW_W-1:0]    cursor_row_o,
  output logic      [tcce_pkg::COL_W-1:0]    cursor_col_o,
  output logic      [tcce_pkg::ADDR_W-1:0]   cursor_offset_o
);

  tcce_pkg::cfg_t                cfg;
  tcce_pkg::mem_wr_t             mem_wr;
  logic [tcce_pkg::ADDR_W-1:0]   mem_raddr;
  logic [tcce_pkg::DATA_W-1:0]   mem_rdata;

  // Configuration registers.
  tcce_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Screen store.
  tcce_screen_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Operation sequencer.
  tcce_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .char_code_i     (char_code_i),
    .target_col_i    (target_col_i),
    .target_row_i    (target_row_i),
    .cell_index_i    (cell_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cell_data_o     (cell_data_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_col_o    (cursor_col_o),
    .cursor_offset_o (cursor_offset_o),
    .mem_wr_o        (mem_wr),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/tcce_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the attributes and the arrow key codes.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tcce_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tcce_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tcce_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output tcce_pkg::cfg_t                     cfg_o
);

  tcce_pkg::cfg_t                   cfg_q;
  logic [tcce_pkg::REG_W-1:0]       reg_idx;
  logic [tcce_pkg::CHAR_W-1:0]      rd_byte;
  logic                             wr_en;

  assign reg_idx = paddr[tcce_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_attr  <= tcce_pkg::RST_TEXT_ATTR;
      cfg_q.blank_attr <= tcce_pkg::RST_BLANK_ATTR;
      cfg_q.code_left  <= tcce_pkg::RST_CODE_LEFT;
      cfg_q.code_right <= tcce_pkg::RST_CODE_RIGHT;
      cfg_q.code_up    <= tcce_pkg::RST_CODE_UP;
      cfg_q.code_down  <= tcce_pkg::RST_CODE_DOWN;
    end else if (wr_en) begin
      unique case (reg_idx)
        tcce_pkg::REG_TEXT_ATTR:  cfg_q.text_attr  <= pwdata[tcce_pkg::CHAR_W-1:0];
        tcce_pkg::REG_BLANK_ATTR: cfg_q.blank_attr <= pwdata[tcce_pkg::CHAR_W-1:0];
        tcce_pkg::REG_CODE_LEFT:  cfg_q.code_left  <= pwdata[tcce_pkg::CHAR_W-1:0];
        tcce_pkg::REG_CODE_RIGHT: cfg_q.code_right <= pwdata[tcce_pkg::CHAR_W-1:0];
        tcce_pkg::REG_CODE_UP:    cfg_q.code_up    <= pwdata[tcce_pkg::CHAR_W-1:0];
        tcce_pkg::REG_CODE_DOWN:  cfg_q.code_down  <= pwdata[tcce_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux; unused addresses read as zero.
  always_comb begin
    unique case (reg_idx)
      tcce_pkg::REG_TEXT_ATTR:  rd_byte = cfg_q.text_attr;
      tcce_pkg::REG_BLANK_ATTR: rd_byte = cfg_q.blank_attr;
      tcce_pkg::REG_CODE_LEFT:  rd_byte = cfg_q.code_left;
      tcce_pkg::REG_CODE_RIGHT: rd_byte = cfg_q.code_right;
      tcce_pkg::REG_CODE_UP:    rd_byte = cfg_q.code_up;
      tcce_pkg::REG_CODE_DOWN:  rd_byte = cfg_q.code_down;
      default:                  rd_byte = '0;
    endcase
  end

  assign prdata = {{(tcce_pkg::PDATA_W - tcce_pkg::CHAR_W){1'b0}}, rd_byte};

endmodule

`default_nettype wire

// ----- rtl/tcce_screen_ram.sv -----
// ----------------------------------------------------------------------------
// Screen store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_screen_ram (
  input  wire logic                         clk_i,
  input  wire tcce_pkg::mem_wr_t            wr_i,
  input  wire logic [tcce_pkg::ADDR_W-1:0]  raddr_i,
  output logic      [tcce_pkg::DATA_W-1:0]  rdata_o
);

  logic [tcce_pkg::DATA_W-1:0] mem_q [tcce_pkg::CELLS];
  logic [tcce_pkg::DATA_W-1:0] rdata_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/tcce_addr_unit.sv -----
// ----------------------------------------------------------------------------
// Cell address unit
// Shared row and column to linear cell address conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_addr_unit (
  input  wire logic [tcce_pkg::ROW_W-1:0]  row_i,
  input  wire logic [tcce_pkg::COL_W-1:0]  col_i,
  output logic      [tcce_pkg::ADDR_W-1:0] addr_o
);

  // Multiply by a constant row pitch and add the column.
  assign addr_o = tcce_pkg::ADDR_W'(row_i) * tcce_pkg::ADDR_W'(tcce_pkg::COLUMNS)
                + tcce_pkg::ADDR_W'(col_i);

endmodule

`default_nettype wire

// ----- rtl/tcce_seq.sv -----
// ----------------------------------------------------------------------------
// Console sequencer
// Steps each operation through the screen store, one cell per cycle where it
// touches several cells, and holds the cursor and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tcce_pkg::cfg_t                cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [tcce_pkg::CHAR_W-1:0]   char_code_i,
  input  wire logic [tcce_pkg::COL_W-1:0]    target_col_i,
  input  wire logic [tcce_pkg::ROW_W-1:0]    target_row_i,
  input  wire logic [tcce_pkg::ADDR_W-1:0]   cell_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [tcce_pkg::DATA_W-1:0]   cell_data_o,
  output logic      [tcce_pkg::ROW_W-1:0]    cursor_row_o,
  output logic      [tcce_pkg::COL_W-1:0]    cursor_col_o,
  output logic      [tcce_pkg::ADDR_W-1:0]   cursor_offset_o,
  output tcce_pkg::mem_wr_t                  mem_wr_o,
  output logic      [tcce_pkg::ADDR_W-1:0]   mem_raddr_o,
  input  wire logic [tcce_pkg::DATA_W-1:0]   mem_rdata_i
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_NL,
    S_SCROLL,
    S_FILL,
    S_MARK,
    S_CLR,
    S_BS,
    S_RD,
    S_DONE
  } state_e;

  localparam logic [tcce_pkg::ROW_W-1:0]  LAST_ROW = tcce_pkg::ROW_W'(tcce_pkg::TEXT_ROWS - 1);
  localparam logic [tcce_pkg::COL_W-1:0]  LAST_COL = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
  localparam logic [tcce_pkg::COL_W-1:0]  TAB_LIMIT =
    tcce_pkg::COL_W'(tcce_pkg::COLUMNS - tcce_pkg::TAB_EDGE - 1);
  localparam logic [tcce_pkg::PTR_W-1:0]  PTR_CELLS = tcce_pkg::PTR_W'(tcce_pkg::CELLS);
  localparam logic [tcce_pkg::PTR_W-1:0]  PTR_LAST  = tcce_pkg::PTR_W'(tcce_pkg::CELLS - 1);
  localparam logic [tcce_pkg::PTR_W-1:0]  PTR_ROW1  = tcce_pkg::PTR_W'(tcce_pkg::COLUMNS);
  localparam logic [tcce_pkg::PTR_W-1:0]  PTR_BOTTOM =
    tcce_pkg::PTR_W'(tcce_pkg::CELLS - tcce_pkg::COLUMNS);
  localparam logic [tcce_pkg::PTR_W-1:0]  PTR_BACK  = tcce_pkg::PTR_W'(tcce_pkg::COLUMNS + 1);

  state_e                          state_q, state_d;
  logic [tcce_pkg::ROW_W-1:0]      row_q, row_d;
  logic [tcce_pkg::COL_W-1:0]      col_q, col_d;
  logic [tcce_pkg::PTR_W-1:0]      ptr_q, ptr_d;
  logic [tcce_pkg::CHAR_W-1:0]     put_char_q, put_char_d;
  logic [tcce_pkg::CNT_W-1:0]      put_cnt_q, put_cnt_d;
  logic                            bs_chk_q, bs_chk_d;
  logic [tcce_pkg::ADDR_W-1:0]     bs_addr_q, bs_addr_d;
  logic [tcce_pkg::DATA_W-1:0]     data_q, data_d;
  logic                            out_valid_q, out_valid_d;
  logic [tcce_pkg::DATA_W-1:0]     out_data_q, out_data_d;
  logic [tcce_pkg::ROW_W-1:0]      out_row_q, out_row_d;
  logic [tcce_pkg::COL_W-1:0]      out_col_q, out_col_d;
  logic [tcce_pkg::ADDR_W-1:0]     out_off_q, out_off_d;

  logic [tcce_pkg::ROW_W-1:0]      au_row;
  logic [tcce_pkg::COL_W-1:0]      au_col;
  logic [tcce_pkg::ADDR_W-1:0]     au_addr;

  logic                            ar_hit;
  logic [tcce_pkg::ROW_W-1:0]      ar_row;
  logic [tcce_pkg::COL_W-1:0]      ar_col;

  logic [tcce_pkg::DATA_W-1:0]     blank_cell;
  logic [tcce_pkg::DATA_W-1:0]     text_cell;
  logic [tcce_pkg::DATA_W-1:0]     mark_cell;

  // Shared address unit, steered by the sequencer.
  tcce_addr_unit u_addr (
    .row_i  (au_row),
    .col_i  (au_col),
    .addr_o (au_addr)
  );

  assign blank_cell = {cfg_i.blank_attr, tcce_pkg::CH_NUL};
  assign mark_cell  = {cfg_i.blank_attr, tcce_pkg::CH_SPACE};
  assign text_cell  = {cfg_i.text_attr, put_char_q};

  // Arrow moves, applied in the order left, right, up, down.
  always_comb begin
    ar_hit = 1'b0;
    ar_row = row_q;
    ar_col = col_q;
    if (char_code_i == cfg_i.code_left) begin
      ar_hit = 1'b1;
      if (ar_col != '0) ar_col = ar_col - 1'b1;
    end
    if (char_code_i == cfg_i.code_right) begin
      ar_hit = 1'b1;
      if (ar_col < LAST_COL) ar_col = ar_col + 1'b1;
    end
    if (char_code_i == cfg_i.code_up) begin
      ar_hit = 1'b1;
      if (ar_row != '0) ar_row = ar_row - 1'b1;
    end
    if (char_code_i == cfg_i.code_down) begin
      ar_hit = 1'b1;
      if (ar_row < LAST_ROW) ar_row = ar_row + 1'b1;
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    ptr_d       = ptr_q;
    put_char_d  = put_char_q;
    put_cnt_d   = put_cnt_q;
    bs_chk_d    = bs_chk_q;
    bs_addr_d   = bs_addr_q;
    data_d      = data_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_off_d   = out_off_q;
    au_row      = row_q;
    au_col      = col_q;
    mem_wr_o    = '0;
    mem_raddr_o = '0;

    // The result register empties when its transaction completes.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      // Clearing pass after reset: every cell to zero.
      S_INIT: begin
        mem_wr_o.we   = 1'b1;
        mem_wr_o.addr = ptr_q[tcce_pkg::ADDR_W-1:0];
        mem_wr_o.data = '0;
        if (ptr_q == PTR_LAST) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      // Accept a transaction and dispatch it.
      S_IDLE: begin
        if (in_valid_i) begin
          data_d = '0;
          unique case (tcce_pkg::func_e'(func_i))
            tcce_pkg::FUNC_PUT: begin
              if (char_code_i == tcce_pkg::CH_NEWLINE) begin
                put_cnt_d = '0;
                state_d   = S_NL;
              end else if (char_code_i == tcce_pkg::CH_TAB) begin
                if (col_q > TAB_LIMIT) begin
                  put_cnt_d = '0;
                  state_d   = S_NL;
                end else begin
                  put_char_d = tcce_pkg::CH_SPACE;
                  put_cnt_d  = tcce_pkg::CNT_W'(tcce_pkg::TAB_WIDTH)
                             - tcce_pkg::CNT_W'(col_q % tcce_pkg::TAB_WIDTH);
                  state_d    = S_PUT;
                end
              end else if (char_code_i == tcce_pkg::CH_BACKSPACE) begin
                bs_chk_d = 1'b0;
                state_d  = S_BS;
              end else if (ar_hit) begin
                row_d   = ar_row;
                col_d   = ar_col;
                state_d = S_DONE;
              end else begin
                put_char_d = char_code_i;
                put_cnt_d  = tcce_pkg::CNT_W'(1);
                state_d    = S_PUT;
              end
            end
            tcce_pkg::FUNC_SET: begin
              col_d   = (target_col_i > LAST_COL) ? LAST_COL : target_col_i;
              row_d   = (target_row_i > LAST_ROW) ? LAST_ROW : target_row_i;
              state_d = S_DONE;
            end
            tcce_pkg::FUNC_CLEAR: begin
              ptr_d   = '0;
              state_d = S_CLR;
            end
            tcce_pkg::FUNC_READ: begin
              if (tcce_pkg::PTR_W'(cell_index_i) < PTR_CELLS) begin
                mem_raddr_o = cell_index_i;
                state_d     = S_RD;
              end else begin
                state_d = S_DONE;
              end
            end
          endcase
        end
      end

      // Write one printable byte, or one space of a tab, at the cursor.
      S_PUT: begin
        mem_wr_o.we   = 1'b1;
        mem_wr_o.addr = au_addr;
        mem_wr_o.data = text_cell;
        put_cnt_d     = put_cnt_q - 1'b1;
        if (col_q == LAST_COL) begin
          state_d = S_NL;
        end else begin
          col_d = col_q + 1'b1;
          if (put_cnt_q == tcce_pkg::CNT_W'(1)) begin
            state_d = S_DONE;
          end
        end
      end

      // Newline: advance the row or start a scroll.
      S_NL: begin
        col_d = '0;
        if (row_q >= LAST_ROW) begin
          row_d   = LAST_ROW;
          ptr_d   = PTR_ROW1;
          state_d = S_SCROLL;
        end else begin
          row_d   = row_q + 1'b1;
          state_d = S_MARK;
        end
      end

      // Scroll: read a cell one row down and write it one row up in the next cycle.
      S_SCROLL: begin
        if (ptr_q < PTR_CELLS) begin
          mem_raddr_o = ptr_q[tcce_pkg::ADDR_W-1:0];
        end
        if (ptr_q != PTR_ROW1) begin
          mem_wr_o.we   = 1'b1;
          mem_wr_o.addr = tcce_pkg::ADDR_W'(ptr_q - PTR_BACK);
          mem_wr_o.data = mem_rdata_i;
        end
        if (ptr_q == PTR_CELLS) begin
          ptr_d   = PTR_BOTTOM;
          state_d = S_FILL;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      // Blank the bottom row after a scroll.
      S_FILL: begin
        mem_wr_o.we   = 1'b1;
        mem_wr_o.addr = ptr_q[tcce_pkg::ADDR_W-1:0];
        mem_wr_o.data = blank_cell;
        if (ptr_q == PTR_LAST) begin
          state_d = S_MARK;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      // Put a blank space in the first cell of the new line.
      S_MARK: begin
        au_col        = '0;
        mem_wr_o.we   = 1'b1;
        mem_wr_o.addr = au_addr;
        mem_wr_o.data = mark_cell;
        state_d       = (put_cnt_q != '0) ? S_PUT : S_DONE;
      end

      // Clear screen: every cell to the blank attribute.
      S_CLR: begin
        mem_wr_o.we   = 1'b1;
        mem_wr_o.addr = ptr_q[tcce_pkg::ADDR_W-1:0];
        mem_wr_o.data = blank_cell;
        if (ptr_q == PTR_LAST) begin
          state_d = S_DONE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      // Backspace: check the cell read last cycle, else step back and read.
      S_BS: begin
        if (bs_chk_q && (mem_rdata_i[tcce_pkg::CHAR_W-1:0] != tcce_pkg::CH_NUL)) begin
          mem_wr_o.we   = 1'b1;
          mem_wr_o.addr = bs_addr_q;
          mem_wr_o.data = blank_cell;
          state_d       = S_DONE;
        end else if ((row_q == '0) && (col_q == '0)) begin
          state_d = S_DONE;
        end else begin
          if (col_q == '0) begin
            au_row = row_q - 1'b1;
            au_col = LAST_COL;
          end else begin
            au_col = col_q - 1'b1;
          end
          row_d       = au_row;
          col_d       = au_col;
          mem_raddr_o = au_addr;
          bs_addr_d   = au_addr;
          bs_chk_d    = 1'b1;
        end
      end

      // Read cell: capture the registered read data.
      S_RD: begin
        data_d  = mem_rdata_i;
        state_d = S_DONE;
      end

      // Load the result register once it is free.
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = data_q;
          out_row_d   = row_q;
          out_col_d   = col_q;
          out_off_d   = au_addr;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State, cursor and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      row_q       <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      put_char_q  <= '0;
      put_cnt_q   <= '0;
      bs_chk_q    <= 1'b0;
      bs_addr_q   <= '0;
      data_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_off_q   <= '0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      ptr_q       <= ptr_d;
      put_char_q  <= put_char_d;
      put_cnt_q   <= put_cnt_d;
      bs_chk_q    <= bs_chk_d;
      bs_addr_q   <= bs_addr_d;
      data_q      <= data_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      out_off_q   <= out_off_d;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign cell_data_o     = out_data_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_col_o    = out_col_q;
  assign cursor_offset_o = out_off_q;

`ifndef SYNTHESIS
  // The cursor always stays on the text area.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= LAST_ROW) && (col_q <= LAST_COL))
    else $error("cursor left the text area");

  // Every store write lands inside the store.
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_o.we |-> (tcce_pkg::PTR_W'(mem_wr_o.addr) < PTR_CELLS))
    else $error("store write out of range");

  // An accepted transaction moves the sequencer out of idle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("sequencer stayed idle after a transaction");

  // A finished operation with a free result register presents its result.
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && !out_valid_q) |=> out_valid_q)
    else $error("finished operation produced no result");

  // The scroll never writes over the cell it reads in the same cycle.
  a_scroll_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCROLL) && mem_wr_o.we && (ptr_q < PTR_CELLS))
      |-> (mem_wr_o.addr != mem_raddr_o))
    else $error("scroll write collides with its read");
`endif

endmodule

`default_nettype wire
